[rtl/core/irs_pkg.sv]
// shared types, constants and coordinate helpers for the image scaler
`default_nettype none
package irs_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 4;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 8;
    localparam int CH_W   = 2;
    localparam int PIX_W  = 8;
    localparam int SIZE_W = 9;
    localparam int STEP_W = 24;
    localparam int FRAC_W = 16;
    localparam int PROD_W = SIZE_W + STEP_W;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;

    localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1) + CH_W;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int WGT_W      = 33;
    localparam int TERM_W     = WGT_W + PIX_W;

    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_COLUMN_STEP   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW_STEP      = 3'd3;
    localparam logic [IDX_W-1:0] REG_USE_BILINEAR  = 3'd4;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] source_width;
        logic [SIZE_W-1:0] source_height;
        logic [STEP_W-1:0] column_step;
        logic [STEP_W-1:0] row_step;
        logic              use_bilinear;
    } cfg_t;

    // one classified word handed from front to back
    typedef struct packed {
        logic              is_read;
        logic [CH_W-1:0]   ch;
        logic [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]  x0;
        logic [COL_W-1:0]  x1;
        logic [ROW_W-1:0]  y0;
        logic [ROW_W-1:0]  y1;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } qword_t;

    typedef struct packed {
        logic [7:0]        lo;
        logic [7:0]        hi;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    // size register as used: zero reads as one, above maximum saturates
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                   input logic [SIZE_W-1:0] mx);
        logic [SIZE_W-1:0] e;
        if (r == '0)
            e = SIZE_W'(1);
        else if (r > mx)
            e = mx;
        else
            e = r;
        return e;
    endfunction

    // clamp a signed integer position to 0 .. size - 1
    function automatic logic [7:0] clamp_pos(input logic signed [17:0] v,
                                             input logic [SIZE_W-1:0] es);
        logic [SIZE_W-1:0] top;
        logic [7:0]        r;
        top = es - SIZE_W'(1);
        if (v < 0)
            r = '0;
        else if (v >= $signed({9'b0, es}))
            r = top[7:0];
        else
            r = v[7:0];
        return r;
    endfunction

    // map one axis: product (2d+1)*step to neighbour positions and weight
    function automatic axis_t axis_map(input logic [PROD_W-1:0] p,
                                       input logic [SIZE_W-1:0] es,
                                       input logic bil);
        logic signed [33:0] s;
        logic signed [33:0] n;
        logic signed [17:0] fi;
        logic signed [17:0] ni;
        axis_t              a;
        s  = $signed({2'b00, p[PROD_W-1:1]}) - 34'sd32768;
        n  = s + 34'sd32768;
        fi = s[33:16];
        ni = (s < 0) ? 18'sd0 : n[33:16];
        if (bil)
        begin
            a.lo   = clamp_pos(fi, es);
            a.hi   = clamp_pos(fi + 18'sd1, es);
            a.frac = s[15:0];
        end
        else
        begin
            a.lo   = clamp_pos(ni, es);
            a.hi   = a.lo;
            a.frac = '0;
        end
        return a;
    endfunction

endpackage
`default_nettype wire

[rtl/core/irs_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module irs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/core/irs_front.sv]
// front end: takes items, maps coordinates and classifies them into queue words
`default_nettype none
module irs_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  mode,
    input  wire logic [irs_pkg::COL_W-1:0] column,
    input  wire logic [irs_pkg::ROW_W-1:0] row,
    input  wire logic [irs_pkg::CH_W-1:0]  channel,
    input  wire logic [irs_pkg::PIX_W-1:0] pixel_in,
    input  wire irs_pkg::cfg_t         cfg,
    input  wire logic                  push_ok,
    output      logic                  busy,
    output      logic                  push,
    output      irs_pkg::qword_t       push_word
);
    import irs_pkg::*;

    logic              f1_valid_reg, f1_valid_next;
    logic              f1_mode_reg;
    logic [COL_W-1:0]  f1_col_reg;
    logic [ROW_W-1:0]  f1_row_reg;
    logic [CH_W-1:0]   f1_ch_reg;
    logic [PIX_W-1:0]  f1_pix_reg;

    logic              f2_valid_reg, f2_valid_next;
    logic              f2_mode_reg;
    logic [COL_W-1:0]  f2_col_reg;
    logic [ROW_W-1:0]  f2_row_reg;
    logic [CH_W-1:0]   f2_ch_reg;
    logic [PIX_W-1:0]  f2_pix_reg;
    logic [PROD_W-1:0] f2_px_reg;
    logic [PROD_W-1:0] f2_py_reg;

    logic              adv;
    logic              accept;
    logic [PROD_W-1:0] px;
    logic [PROD_W-1:0] py;
    logic [SIZE_W-1:0] ew;
    logic [SIZE_W-1:0] eh;
    axis_t             ax;
    axis_t             ay;

    // pipeline moves unless the last stage cannot hand over its word
    assign adv    = push_ok || !f2_valid_reg;
    assign busy   = !adv;
    assign accept = start && adv;

    // centre mapping products (2d + 1) * step
    assign px = PROD_W'({f1_col_reg, 1'b1}) * PROD_W'(cfg.column_step);
    assign py = PROD_W'({f1_row_reg, 1'b1}) * PROD_W'(cfg.row_step);

    assign f1_valid_next = adv ? accept : f1_valid_reg;
    assign f2_valid_next = adv ? f1_valid_reg : f2_valid_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_mode_reg <= mode;
            f1_col_reg  <= column;
            f1_row_reg  <= row;
            f1_ch_reg   <= channel;
            f1_pix_reg  <= pixel_in;
            f2_mode_reg <= f1_mode_reg;
            f2_col_reg  <= f1_col_reg;
            f2_row_reg  <= f1_row_reg;
            f2_ch_reg   <= f1_ch_reg;
            f2_pix_reg  <= f1_pix_reg;
            f2_px_reg   <= px;
            f2_py_reg   <= py;
        end
    end

    // clamp, floor or round, and build the queue word
    assign ew = eff_size(cfg.source_width, SIZE_W'(MAX_WIDTH));
    assign eh = eff_size(cfg.source_height, SIZE_W'(MAX_HEIGHT));
    assign ax = axis_map(f2_px_reg, ew, cfg.use_bilinear);
    assign ay = axis_map(f2_py_reg, eh, cfg.use_bilinear);

    always_comb
    begin
        push_word.is_read = (f2_mode_reg == MODE_READ);
        push_word.ch      = f2_ch_reg;
        push_word.pixel   = f2_pix_reg;
        if (f2_mode_reg == MODE_READ)
        begin
            push_word.x0 = ax.lo;
            push_word.x1 = ax.hi;
            push_word.y0 = ay.lo;
            push_word.y1 = ay.hi;
            push_word.fx = ax.frac;
            push_word.fy = ay.frac;
        end
        else
        begin
            push_word.x0 = f2_col_reg;
            push_word.x1 = f2_col_reg;
            push_word.y0 = f2_row_reg;
            push_word.y1 = f2_row_reg;
            push_word.fx = '0;
            push_word.fy = '0;
        end
    end

    assign push = f2_valid_reg && push_ok;

    // a stall only ever comes from a held last stage
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> f2_valid_reg)
        else $error("front stalled with empty last stage");
    // a held word stays put while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> f2_valid_reg && $stable(f2_px_reg))
        else $error("stalled word changed");
    // the first stage keeps its word while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (f1_valid_reg && busy) |=> f1_valid_reg)
        else $error("first stage lost a word");

endmodule
`default_nettype wire

[rtl/core/irs_queue.sv]
// two-word queue between front and back
`default_nettype none
module irs_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire irs_pkg::qword_t push_word,
    input  wire logic            pop,
    output      logic            push_ok,
    output      logic            not_empty,
    output      irs_pkg::qword_t head
);
    import irs_pkg::*;

    qword_t     store_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign not_empty = (cnt_reg != 2'd0);
    assign push_ok   = (cnt_reg != 2'd2) || pop;
    assign head      = store_reg[rptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wptr_reg] <= push_word;
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count lost a push");

endmodule
`default_nettype wire

[rtl/core/irs_back.sv]
// back end: banked frame store, four-tap blend and rounding
`default_nettype none
module irs_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            not_empty,
    input  wire irs_pkg::qword_t head,
    output      logic            pop,
    output      logic            done,
    output      logic [irs_pkg::PIX_W-1:0] pixel_out
);
    import irs_pkg::*;

    logic [BANK_AW-1:0] bank_addr [4];
    logic [3:0]         bank_we;
    logic [PIX_W-1:0]   bank_rd [4];

    logic [16:0]        ex;
    logic [16:0]        ey;
    logic [33:0]        m00, m10, m01, m11;

    logic               b2_valid_reg;
    logic [1:0]         b2_sel_reg [4];
    logic [WGT_W-1:0]   b2_w_reg [4];

    logic               b3_valid_reg;
    logic [TERM_W-1:0]  b3_t_reg [4];
    logic [TERM_W-1:0]  term [4];

    logic [TERM_W+1:0]  total;
    logic [10:0]        rounded;
    logic [PIX_W-1:0]   clipped;

    logic               done_reg;
    logic [PIX_W-1:0]   pixel_reg;

    // the back end never stalls
    assign pop = not_empty;

    // bank addressing: each parity bank takes whichever neighbour has its parity
    genvar k;
    generate
        for (k = 0; k < 4; k++)
        begin : g_bank
            logic [ROW_W-1:0] rsel;
            logic [COL_W-1:0] csel;
            assign rsel = (head.y0[0] == k[1]) ? head.y0 : head.y1;
            assign csel = (head.x0[0] == k[0]) ? head.x0 : head.x1;
            assign bank_addr[k] = {rsel[ROW_W-1:1], csel[COL_W-1:1], head.ch};
            assign bank_we[k]   = pop && !head.is_read
                                  && ({head.y0[0], head.x0[0]} == 2'(k));
            irs_ram #(
                .WIDTH (PIX_W),
                .DEPTH (BANK_DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (bank_we[k]),
                .waddr (bank_addr[k]),
                .wdata (head.pixel),
                .raddr (bank_addr[k]),
                .rdata (bank_rd[k])
            );
        end
    endgenerate

    // bilinear weight products, Q1.16 by Q1.16
    assign ex  = 17'h10000 - {1'b0, head.fx};
    assign ey  = 17'h10000 - {1'b0, head.fy};
    assign m00 = 34'(ex) * 34'(ey);
    assign m10 = 34'({1'b0, head.fx}) * 34'(ey);
    assign m01 = 34'(ex) * 34'({1'b0, head.fy});
    assign m11 = 34'({1'b0, head.fx}) * 34'({1'b0, head.fy});

    // control valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b2_valid_reg <= pop && head.is_read;
            b3_valid_reg <= b2_valid_reg;
            done_reg     <= b3_valid_reg;
        end
    end

    // weights and bank selects alongside the ram read
    always_ff @(posedge clk)
    begin
        b2_sel_reg[0] <= {head.y0[0], head.x0[0]};
        b2_sel_reg[1] <= {head.y0[0], head.x1[0]};
        b2_sel_reg[2] <= {head.y1[0], head.x0[0]};
        b2_sel_reg[3] <= {head.y1[0], head.x1[0]};
        b2_w_reg[0]   <= m00[WGT_W-1:0];
        b2_w_reg[1]   <= m10[WGT_W-1:0];
        b2_w_reg[2]   <= m01[WGT_W-1:0];
        b2_w_reg[3]   <= m11[WGT_W-1:0];
    end

    // weight times neighbour value
    always_comb
    begin
        for (int j = 0; j < 4; j++)
            term[j] = TERM_W'(b2_w_reg[j]) * TERM_W'(bank_rd[b2_sel_reg[j]]);
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
            b3_t_reg[j] <= term[j];
    end

    // sum, round to nearest and saturate
    assign total   = (TERM_W+2)'(b3_t_reg[0]) + (TERM_W+2)'(b3_t_reg[1])
                   + (TERM_W+2)'(b3_t_reg[2]) + (TERM_W+2)'(b3_t_reg[3])
                   + ((TERM_W+2)'(1) << 31);
    assign rounded = total[TERM_W+1:32];
    assign clipped = (rounded > 11'd255) ? 8'hFF : rounded[PIX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (b3_valid_reg)
            pixel_reg <= clipped;
    end

    assign done      = done_reg;
    assign pixel_out = pixel_reg;

    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(bank_we))
        else $error("more than one bank written");
    assert property (@(posedge clk) disable iff (!rst_n)
        bank_we != 4'b0000 |-> !head.is_read)
        else $error("read word wrote the frame store");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pop && head.is_read, 3))
        else $error("result without matching read");

endmodule
`default_nettype wire

[rtl/core/image_resize_nearest_bilinear.sv]
// top level of the nearest and bilinear image scaler
// Use: an item is taken on a rising edge with start high and busy low.
// mode low writes pixel_in into the frame store at column, row, channel;
// mode high asks for destination pixel (column, row, channel) and gives
// one word on pixel_out, marked by done for exactly one cycle.
// Writes give no result. Words come out in request order.
// The front maps (2d + 1) * step onto the source grid, floors or rounds
// and clamps; a two-word queue hands words to the back, which reads four
// parity banks (row and column parity) in parallel and blends them.
// A request passes f1, f2, the queue, the bank read, the term and pixel
// registers; the word is taken on the edge that ends its done cycle.
// Throughput: one item per cycle, sustained; the back end never stalls,
// so busy stays low in normal use. Registers are set through cfg_we,
// cfg_index, cfg_data while idle, a rule for the user that the block
// does not enforce. Reset clears the pipeline and restores register
// defaults; the frame store holds no defined data until written.
// The receiver cannot stall: a result is taken in its one done cycle.
`default_nettype none
module image_resize_nearest_bilinear (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output      logic                      busy,
    input  wire logic                      mode,
    input  wire logic [irs_pkg::COL_W-1:0] column,
    input  wire logic [irs_pkg::ROW_W-1:0] row,
    input  wire logic [irs_pkg::CH_W-1:0]  channel,
    input  wire logic [irs_pkg::PIX_W-1:0] pixel_in,
    output      logic                      done,
    output      logic [irs_pkg::PIX_W-1:0] pixel_out,
    input  wire logic                      cfg_we,
    input  wire logic [irs_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [irs_pkg::CFG_W-1:0] cfg_data
);
    import irs_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   push;
    logic   push_ok;
    logic   pop;
    logic   not_empty;
    qword_t push_word;
    qword_t head;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  cfg_next.source_width  = cfg_data[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: cfg_next.source_height = cfg_data[SIZE_W-1:0];
                REG_COLUMN_STEP:   cfg_next.column_step   = cfg_data[STEP_W-1:0];
                REG_ROW_STEP:      cfg_next.row_step      = cfg_data[STEP_W-1:0];
                REG_USE_BILINEAR:  cfg_next.use_bilinear  = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width  <= SIZE_W'(MAX_WIDTH);
            cfg_reg.source_height <= SIZE_W'(MAX_HEIGHT);
            cfg_reg.column_step   <= STEP_W'(65536);
            cfg_reg.row_step      <= STEP_W'(65536);
            cfg_reg.use_bilinear  <= 1'b1;
        end
        else
            cfg_reg <= cfg_next;
    end

    // front: take and classify
    irs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .column    (column),
        .row       (row),
        .channel   (channel),
        .pixel_in  (pixel_in),
        .cfg       (cfg_reg),
        .push_ok   (push_ok),
        .busy      (busy),
        .push      (push),
        .push_word (push_word)
    );

    // decoupling queue
    irs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .push_ok   (push_ok),
        .not_empty (not_empty),
        .head      (head)
    );

    // back: frame store and blend
    irs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .done      (done),
        .pixel_out (pixel_out)
    );

endmodule
`default_nettype wire

[tb/image_resize_nearest_bilinear_check.sv]
// checker for the image scaler: mirrors the frame store and predicts each pixel word
`timescale 1ns / 100ps
module image_resize_nearest_bilinear_check (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire logic                      mode,
    input  wire logic [irs_pkg::COL_W-1:0] column,
    input  wire logic [irs_pkg::ROW_W-1:0] row,
    input  wire logic [irs_pkg::CH_W-1:0]  channel,
    input  wire logic [irs_pkg::PIX_W-1:0] pixel_in,
    input  wire logic                      done,
    input  wire logic [irs_pkg::PIX_W-1:0] pixel_out,
    input  wire logic                      cfg_we,
    input  wire logic [irs_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [irs_pkg::CFG_W-1:0] cfg_data,
    output int                             errors,
    output int                             pending
);
    import irs_pkg::*;

    logic [PIX_W-1:0]  shadow_store [0:MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS-1];
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [STEP_W-1:0] col_step;
    logic [STEP_W-1:0] row_step;
    logic              bilinear;
    logic [PIX_W-1:0]  expected_pixels [$];

    // size as used by the scaler
    function automatic int used_size(logic [SIZE_W-1:0] r, int mx);
        if (r == 0)
            return 1;
        if (r > mx)
            return mx;
        return r;
    endfunction

    function automatic int clamp_axis(longint p, int sz);
        if (p < 0)
            return 0;
        if (p >= sz)
            return sz - 1;
        return int'(p);
    endfunction

    function automatic longint fetch_texel(longint x, longint y, int ch);
        int cx;
        int cy;
        cx = clamp_axis(x, used_size(src_w, MAX_WIDTH));
        cy = clamp_axis(y, used_size(src_h, MAX_HEIGHT));
        return longint'(shadow_store[(cy * MAX_WIDTH + cx) * MAX_CHANNELS + ch]);
    endfunction

    // destination centre onto the source grid, signed q16
    function automatic longint source_coord(int d, logic [STEP_W-1:0] stp);
        longint p;
        p = ((2 * longint'(d) + 1) * longint'(stp)) >>> 1;
        return p - 32768;
    endfunction

    function automatic logic [PIX_W-1:0] scaled_pixel(int col, int rw, int ch);
        longint sx;
        longint sy;
        longint ix;
        longint iy;
        longint dx;
        longint dy;
        longint sum;
        longint nx;
        longint ny;
        sx = source_coord(col, col_step);
        sy = source_coord(rw, row_step);
        if (!bilinear)
        begin
            nx = (sx >= 0) ? ((sx + 32768) >>> 16) : -((-sx + 32768) >>> 16);
            ny = (sy >= 0) ? ((sy + 32768) >>> 16) : -((-sy + 32768) >>> 16);
            return fetch_texel(nx, ny, ch);
        end
        ix = sx >>> 16;
        iy = sy >>> 16;
        dx = sx - ix * 65536;
        dy = sy - iy * 65536;
        sum = (65536 - dx) * (65536 - dy) * fetch_texel(ix, iy, ch)
            + dx * (65536 - dy) * fetch_texel(ix + 1, iy, ch)
            + (65536 - dx) * dy * fetch_texel(ix, iy + 1, ch)
            + dx * dy * fetch_texel(ix + 1, iy + 1, ch);
        sum = (sum + (longint'(1) << 31)) >>> 32;
        return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    // compare finished words, then take new words and register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w    = 9'd256;
            src_h    = 9'd256;
            col_step = 24'd65536;
            row_step = 24'd65536;
            bilinear = 1'b1;
            expected_pixels.delete();
            pending  = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel_out: unexpected word, actual %0d", pixel_out);
                    errors++;
                end
                else
                begin
                    if (pixel_out !== expected_pixels[0])
                    begin
                        $error("pixel_out: expected %0d, actual %0d",
                               expected_pixels[0], pixel_out);
                        errors++;
                    end
                    void'(expected_pixels.pop_front());
                end
            end
            if (start && !busy)
            begin
                if (mode == MODE_WRITE)
                    shadow_store[(int'(row) * MAX_WIDTH + column) * MAX_CHANNELS + channel]
                        = pixel_in;
                else
                    expected_pixels.push_back(scaled_pixel(column, row, channel));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  src_w    = cfg_data[SIZE_W-1:0];
                    REG_SOURCE_HEIGHT: src_h    = cfg_data[SIZE_W-1:0];
                    REG_COLUMN_STEP:   col_step = cfg_data[STEP_W-1:0];
                    REG_ROW_STEP:      row_step = cfg_data[STEP_W-1:0];
                    REG_USE_BILINEAR:  bilinear = cfg_data[0];
                    default: ;
                endcase
            end
            pending = expected_pixels.size();
        end
    end

endmodule

[tb/image_resize_nearest_bilinear_test.sv]
// top of the image scaler testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module image_resize_nearest_bilinear_test;
    import irs_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              mode;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [CH_W-1:0]   channel;
    logic [PIX_W-1:0]  pixel_in;
    logic              done;
    logic [PIX_W-1:0]  pixel_out;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                errors;
    int                pending;
    int                stall_cycles;
    logic              steady;
    int                cur_w;
    int                cur_h;
    int                cur_ch;
    bit                loaded [0:MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS-1];

    image_resize_nearest_bilinear i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .column    (column),
        .row       (row),
        .channel   (channel),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    image_resize_nearest_bilinear_check i_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .column    (column),
        .row       (row),
        .channel   (channel),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on cycles with no traffic
    initial stall_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("image_resize_nearest_bilinear test failed");
            $finish;
        end
    end

    // one word in, with random idle cycles ahead of it unless steady is set
    task automatic send_word(logic md, int c, int r, int ch, int px);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        mode     <= md;
        column   <= c[COL_W-1:0];
        row      <= r[ROW_W-1:0];
        channel  <= ch[CH_W-1:0];
        pixel_in <= px[PIX_W-1:0];
        // busy is settled at the falling edge for the coming rising edge
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // let every request drain, then allow for the pipeline depth
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // new setting, then load every source entry that a request may touch
    task automatic set_up(int w, int h, int cs, int rs, int bil, int nch);
        drain();
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
        write_reg(REG_COLUMN_STEP, cs);
        write_reg(REG_ROW_STEP, rs);
        write_reg(REG_USE_BILINEAR, bil);
        cur_w  = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        cur_h  = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        cur_ch = nch;
        for (int r = 0; r < cur_h; r++)
            for (int c = 0; c < cur_w; c++)
                for (int ch = 0; ch < cur_ch; ch++)
                    if (!loaded[(r * MAX_WIDTH + c) * MAX_CHANNELS + ch])
                    begin
                        loaded[(r * MAX_WIDTH + c) * MAX_CHANNELS + ch] = 1'b1;
                        send_word(MODE_WRITE, c, r, ch, $urandom_range(255));
                    end
    endtask

    function automatic int pick_step();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2:       return 24'hFFFFFF;
            3:       return $urandom_range(24'hFFFFFF);
            4, 5:    return 65536;
            default: return $urandom_range(24'h3FFFF);
        endcase
    endfunction

    // random mix of requests and writes; writes land anywhere
    task automatic mixed_words(int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 70)
                send_word(MODE_READ, $urandom_range(255), $urandom_range(255),
                          $urandom_range(cur_ch - 1), $urandom_range(255));
            else if ($urandom_range(1))
                send_word(MODE_WRITE, $urandom_range(cur_w - 1), $urandom_range(cur_h - 1),
                          $urandom_range(3), $urandom_range(255));
            else
                send_word(MODE_WRITE, $urandom_range(255), $urandom_range(255),
                          $urandom_range(3), $urandom_range(255));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        mode      = MODE_WRITE;
        column    = '0;
        row       = '0;
        channel   = '0;
        pixel_in  = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady    = 1'b0;
        cur_ch    = MAX_CHANNELS;
        repeat (10) @(posedge clk);
        rst_n = 1'b0;
        @(negedge clk);
        rst_n = 1'b1;

        // single pixel image, pixel extremes, corner requests in both modes
        set_up(1, 1, 65536, 65536, 1, MAX_CHANNELS);
        send_word(MODE_WRITE, 0, 0, 0, 0);
        send_word(MODE_WRITE, 0, 0, 3, 255);
        send_word(MODE_READ, 0, 0, 0, 0);
        send_word(MODE_READ, 255, 255, 3, 0);
        set_up(1, 1, 65536, 65536, 0, MAX_CHANNELS);
        send_word(MODE_READ, 0, 0, 3, 0);
        send_word(MODE_READ, 255, 255, 0, 0);

        // widest single row: largest, smallest and zero steps
        set_up(256, 1, 24'hFFFFFF, 1, 1, 1);
        send_word(MODE_READ, 0, 0, 0, 0);
        send_word(MODE_READ, 255, 255, 0, 0);
        set_up(256, 1, 1, 0, 0, 1);
        send_word(MODE_READ, 255, 0, 0, 0);
        send_word(MODE_READ, 0, 255, 0, 0);
        // tallest single column, then sizes out of range
        set_up(1, 256, 0, 24'hFFFFFF, 1, 1);
        send_word(MODE_READ, 7, 255, 0, 0);
        send_word(MODE_READ, 7, 128, 0, 0);
        set_up(511, 1, 32768, 65536, 1, 1);
        mixed_words(20);
        set_up(1, 511, 65536, 98304, 0, 1);
        mixed_words(20);
        set_up(0, 0, 65536, 65536, 1, MAX_CHANNELS);
        mixed_words(10);

        // random settings; a block of phases runs with no idle cycles
        for (int p = 0; p < 30; p++)
        begin
            set_up($urandom_range(1, 8), $urandom_range(1, 8), pick_step(), pick_step(),
                   $urandom_range(1), MAX_CHANNELS);
            steady = (p >= 12 && p < 18);
            mixed_words(25);
        end
        steady = 1'b0;

        drain();
        if (errors == 0 && pending == 0)
            $display("image_resize_nearest_bilinear test passed");
        else
            $display("image_resize_nearest_bilinear test failed");
        $finish;
    end

endmodule

[image_resize_nearest_bilinear.f]
rtl/core/irs_pkg.sv
rtl/core/irs_ram.sv
rtl/core/irs_front.sv
rtl/core/irs_queue.sv
rtl/core/irs_back.sv
rtl/core/image_resize_nearest_bilinear.sv
tb/image_resize_nearest_bilinear_check.sv
tb/image_resize_nearest_bilinear_test.sv
